### sv/stpt_pkg.sv
// Shared types and constants for the segment and page translation unit.
// No dependencies; every other file imports this package.
package stpt_pkg;

  localparam int DESC_ENTRIES = 256;
  localparam int PAGE_ENTRIES = 1024;

  localparam int DESC_AW = (DESC_ENTRIES > 1) ? $clog2(DESC_ENTRIES) : 1;
  localparam int PAGE_AW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;

  // Selector index width (bits 15:3); also carries load slots, zero-extended.
  localparam int IDX_W = 13;

  localparam int GCNT_W = 9;
  localparam int PCNT_W = 11;

  // Command queue between front and back.
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_DEPTH = 2 ** CMDQ_AW;

  typedef enum logic [2:0] {
    OP_XLATE      = 3'd0,
    OP_LOAD_GLOBAL = 3'd1,
    OP_LOAD_LOCAL  = 3'd2,
    OP_LOAD_DIR    = 3'd3,
    OP_LOAD_PAGE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_GLOBAL_COUNT    = 2'd0,
    REG_LOCAL_COUNT     = 2'd1,
    REG_DIRECTORY_COUNT = 2'd2,
    REG_PAGETABLE_COUNT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GCNT_W-1:0] global_count;
    logic [GCNT_W-1:0] local_count;
    logic [PCNT_W-1:0] directory_count;
    logic [PCNT_W-1:0] pagetable_count;
  } cfg_t;

  typedef struct packed {
    op_t              kind;
    logic             pre_fail;   // selector already rejected
    logic             tab_local;
    logic [IDX_W-1:0] idx;        // descriptor index or load slot
    logic [63:0]      data;
    logic [31:0]      offs;
  } cmd_t;

endpackage

### sv/stpt_fifo.sv
// Short command queue between the classifier and the table engine.
// Depends on stpt_pkg (cmd_t, queue depth).
module stpt_fifo
  import stpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;

  assign full    = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en && !empty) rd_ptr <= rd_ptr + 1'b1;
      priority if ((wr_en && !full) && !(rd_en && !empty)) begin
        count <= count + 1'b1;
      end else if (!(wr_en && !full) && (rd_en && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/stpt_front.sv
// Front end: decodes input beats, drops ignored ones, pre-checks selectors.
// Depends on stpt_pkg (op codes, cmd_t, cfg_t).
module stpt_front
  import stpt_pkg::*;
(
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [9:0]  entry_index,
  input  logic [63:0] entry_data,
  input  logic [31:0] logical_address,
  input  logic [15:0] segment_selector,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic             keep;
  logic [IDX_W-1:0] sel_idx;
  logic [GCNT_W-1:0] cnt;
  logic             desc_slot_ok;
  logic             page_slot_ok;

  assign full    = q_full;
  assign sel_idx = segment_selector[15:3];
  assign cnt     = segment_selector[2] ? cfg.local_count : cfg.global_count;

  assign desc_slot_ok = {4'b0, entry_index} < 14'(DESC_ENTRIES);
  assign page_slot_ok = {1'b0, entry_index} < 11'(PAGE_ENTRIES);

  always_comb begin
    q_cmd.kind      = op_t'(op);
    q_cmd.tab_local = segment_selector[2];
    q_cmd.data      = entry_data;
    q_cmd.offs      = logical_address;
    q_cmd.pre_fail  = (segment_selector[15:2] == '0) ||
                      ({1'b0, sel_idx} >= {5'b0, cnt}) ||
                      ({1'b0, sel_idx} >= 14'(DESC_ENTRIES));
    q_cmd.idx       = sel_idx;
    keep            = 1'b0;
    unique case (op_t'(op))
      OP_XLATE: begin
        keep = 1'b1;
      end
      OP_LOAD_GLOBAL, OP_LOAD_LOCAL: begin
        keep      = desc_slot_ok;
        q_cmd.idx = IDX_W'(entry_index);
      end
      OP_LOAD_DIR, OP_LOAD_PAGE: begin
        keep      = page_slot_ok;
        q_cmd.idx = IDX_W'(entry_index);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Drop ignored beats: accepted here, never queued.
  assign q_push = push && !q_full && keep;

endmodule

### sv/stpt_back.sv
// Back end: the four tables, the two dependent lookups and the result register.
// Depends on stpt_pkg (cmd_t, cfg_t, table sizes).
module stpt_back
  import stpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  input  cfg_t        cfg,
  output logic        res_valid,
  input  logic        res_pop,
  output logic        res_invalid,
  output logic [63:0] res_phys
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DESC = 3'b010,
    ST_PAGE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [63:0] global_mem [DESC_ENTRIES];
  logic [63:0] local_mem  [DESC_ENTRIES];
  logic [63:0] dir_mem    [PAGE_ENTRIES];
  logic [63:0] page_mem   [PAGE_ENTRIES];

  logic [63:0] global_q;
  logic [63:0] local_q;
  logic [63:0] dir_q;
  logic [63:0] page_q;

  logic        tab_local;
  logic [31:0] offs;
  logic        fail;
  logic [11:0] lin_lo;

  logic        out_free;
  logic        take;
  logic        desc_rd;
  logic        page_rd;
  logic        fail_now;

  logic [63:0] desc;
  logic [19:0] limit20;
  logic [31:0] limit;
  logic [31:0] base;
  logic [32:0] lin;
  logic [10:0] dir_idx;
  logic [9:0]  tab_idx;
  logic        load_result;
  logic        result_inv;

  assign out_free = !res_valid || res_pop;

  always_comb begin
    state_next  = state;
    take        = 1'b0;
    desc_rd     = 1'b0;
    page_rd     = 1'b0;
    load_result = 1'b0;
    result_inv  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.kind == OP_XLATE) begin
            if (cmd.pre_fail) begin
              take        = out_free;
              load_result = out_free;
            end else begin
              take       = 1'b1;
              desc_rd    = 1'b1;
              state_next = ST_DESC;
            end
          end else begin
            take = 1'b1;
          end
        end
      end
      ST_DESC: begin
        page_rd    = 1'b1;
        state_next = ST_PAGE;
      end
      ST_PAGE: begin
        result_inv = fail || !dir_q[0] || !page_q[0];
        if (out_free) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign cmd_pop = take;

  // Descriptor decode on the registered read data.
  assign desc    = tab_local ? local_q : global_q;
  assign limit20 = {desc[51:48], desc[15:0]};
  assign limit   = desc[55] ? {limit20, 12'h000} : {12'h000, limit20};
  assign base    = {desc[63:56], desc[39:16]};
  assign lin     = {1'b0, offs} + {1'b0, base};
  assign dir_idx = lin[32:22];
  assign tab_idx = lin[21:12];

  assign fail_now = !desc[47] || (offs > limit) ||
                    (dir_idx >= cfg.directory_count) ||
                    (dir_idx >= 11'(PAGE_ENTRIES)) ||
                    ({1'b0, tab_idx} >= cfg.pagetable_count) ||
                    ({1'b0, tab_idx} >= 11'(PAGE_ENTRIES));

  always_ff @(posedge clk) begin
    if (take && cmd.kind == OP_LOAD_GLOBAL) global_mem[cmd.idx[DESC_AW-1:0]] <= cmd.data;
    if (desc_rd) global_q <= global_mem[cmd.idx[DESC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == OP_LOAD_LOCAL) local_mem[cmd.idx[DESC_AW-1:0]] <= cmd.data;
    if (desc_rd) local_q <= local_mem[cmd.idx[DESC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == OP_LOAD_DIR) dir_mem[cmd.idx[PAGE_AW-1:0]] <= cmd.data;
    if (page_rd) dir_q <= dir_mem[dir_idx[PAGE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == OP_LOAD_PAGE) page_mem[cmd.idx[PAGE_AW-1:0]] <= cmd.data;
    if (page_rd) page_q <= page_mem[tab_idx[PAGE_AW-1:0]];
  end

  // Hold the translate context across the two lookups.
  always_ff @(posedge clk) begin
    if (desc_rd) begin
      tab_local <= cmd.tab_local;
      offs      <= cmd.offs;
    end
    if (page_rd) begin
      fail   <= fail_now;
      lin_lo <= lin[11:0];
    end
    if (load_result) begin
      res_invalid <= result_inv;
      res_phys    <= result_inv ? 64'h0 : {page_q[63:12], lin_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/segment_and_page_translation_unit.sv
// Top level of the segment and page translation unit: register port,
// front classifier, command queue and table engine. Depends on stpt_pkg.
//
//   channel   handshake           beat contents
//   -------   -----------------   ---------------------------------------------
//   input     push / full         op, entry_index, entry_data, logical_address,
//                                 segment_selector
//   result    empty / pop         invalid, physical_address
//   config    psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// A load beat is handled by the table engine in its idle state. A translate
// beat steps through descriptor read, directory and page-table reads, and
// result, ordered by the two dependent synchronous memory lookups; one rejected
// at the selector is answered from idle. The command queue registers each beat.
// Reset clears control state and the count registers; table contents stay
// undefined until loaded. A stalled result holds in the output register while
// the queue keeps taking beats until it fills.
module segment_and_page_translation_unit
  import stpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input queue
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [9:0]  entry_index,
  input  logic [63:0] entry_data,
  input  logic [31:0] logical_address,
  input  logic [15:0] segment_selector,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic        invalid,
  output logic [63:0] physical_address,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  cmd_t q_in;
  cmd_t q_out;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic res_valid;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Count registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GLOBAL_COUNT:    cfg.global_count    <= pwdata[GCNT_W-1:0];
        REG_LOCAL_COUNT:     cfg.local_count     <= pwdata[GCNT_W-1:0];
        REG_DIRECTORY_COUNT: cfg.directory_count <= pwdata[PCNT_W-1:0];
        REG_PAGETABLE_COUNT: cfg.pagetable_count <= pwdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GLOBAL_COUNT:    prdata = 32'(cfg.global_count);
      REG_LOCAL_COUNT:     prdata = 32'(cfg.local_count);
      REG_DIRECTORY_COUNT: prdata = 32'(cfg.directory_count);
      REG_PAGETABLE_COUNT: prdata = 32'(cfg.pagetable_count);
      default:             prdata = '0;
    endcase
  end

  // Classify and pre-check each input beat.
  stpt_front u_front (
    .push             (push),
    .full             (full),
    .op               (op),
    .entry_index      (entry_index),
    .entry_data       (entry_data),
    .logical_address  (logical_address),
    .segment_selector (segment_selector),
    .cfg              (cfg),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_in)
  );

  // Decouple the front from the table engine.
  stpt_fifo u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  // Run loads and lookups in order; hold the result until popped.
  stpt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (q_out),
    .cmd_empty   (q_empty),
    .cmd_pop     (q_pop),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .res_invalid (invalid),
    .res_phys    (physical_address)
  );

  assign empty = !res_valid;

endmodule

### tb/sv/segment_and_page_translation_unit_checker.sv
// Checker for the segment and page translation unit: watches the input, result
// and register channels, predicts each translation and compares result beats.
// Depends on stpt_pkg.
module segment_and_page_translation_unit_checker
  import stpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  op,
  input  logic [9:0]  entry_index,
  input  logic [63:0] entry_data,
  input  logic [31:0] logical_address,
  input  logic [15:0] segment_selector,
  input  logic        empty,
  input  logic        pop,
  input  logic        invalid,
  input  logic [63:0] physical_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding,
  output int          results_checked
);

  typedef struct packed {
    logic        invalid;
    logic [63:0] physical_address;
  } xlate_result_t;

  xlate_result_t awaited_xlates[$];
  xlate_result_t oldest;

  // Shadow tables; only entries below the programmed counts are ever read.
  logic [63:0] gdt_copy [DESC_ENTRIES];
  logic [63:0] ldt_copy [DESC_ENTRIES];
  logic [63:0] dir_copy [PAGE_ENTRIES];
  logic [63:0] pt_copy  [PAGE_ENTRIES];

  logic [GCNT_W-1:0] global_count_q = '0;
  logic [GCNT_W-1:0] local_count_q  = '0;
  logic [PCNT_W-1:0] dir_count_q    = '0;
  logic [PCNT_W-1:0] page_count_q   = '0;

  function automatic int clamp_depth(int c, int depth);
    return (c < depth) ? c : depth;
  endfunction

  // Segment check, then the two-level page walk.
  function automatic xlate_result_t translate_address(logic [31:0] offs, logic [15:0] sel);
    xlate_result_t r;
    logic [63:0]   desc;
    logic [63:0]   pte;
    logic [31:0]   limit;
    logic [31:0]   base;
    logic [32:0]   lin;
    int            idx;
    int            cnt;
    int            dir_idx;
    int            tab_idx;
    r.invalid          = 1'b1;
    r.physical_address = '0;
    if (sel[15:2] == '0) return r;
    idx = int'(sel[15:3]);
    cnt = sel[2] ? clamp_depth(int'(local_count_q), DESC_ENTRIES)
                 : clamp_depth(int'(global_count_q), DESC_ENTRIES);
    if (idx >= cnt) return r;
    desc = sel[2] ? ldt_copy[idx[DESC_AW-1:0]] : gdt_copy[idx[DESC_AW-1:0]];
    if (!desc[47]) return r;
    limit = {12'd0, desc[51:48], desc[15:0]};
    if (desc[55]) limit = limit << 12;
    if (offs > limit) return r;
    base = {desc[63:56], desc[39:16]};
    lin  = {1'b0, offs} + {1'b0, base};
    dir_idx = int'(lin[32:22]);
    if (dir_idx >= clamp_depth(int'(dir_count_q), PAGE_ENTRIES)) return r;
    if (!dir_copy[dir_idx[PAGE_AW-1:0]][0]) return r;
    tab_idx = int'(lin[21:12]);
    if (tab_idx >= clamp_depth(int'(page_count_q), PAGE_ENTRIES)) return r;
    pte = pt_copy[tab_idx[PAGE_AW-1:0]];
    if (!pte[0]) return r;
    r.invalid          = 1'b0;
    r.physical_address = {pte[63:12], lin[11:0]};
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      global_count_q = '0;
      local_count_q  = '0;
      dir_count_q    = '0;
      page_count_q   = '0;
    end else begin
      if (pop && !empty) begin
        if (awaited_xlates.size() == 0) begin
          $error("result beat with no translation outstanding");
          fail_count++;
        end else begin
          oldest = awaited_xlates.pop_front();
          results_checked++;
          if (invalid !== oldest.invalid) begin
            $error("invalid: expected %0d, actual %0d", oldest.invalid, invalid);
            fail_count++;
          end
          if (physical_address !== oldest.physical_address) begin
            $error("physical_address: expected %h, actual %h",
                   oldest.physical_address, physical_address);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        case (op)
          OP_XLATE:
            awaited_xlates.push_back(translate_address(logical_address, segment_selector));
          OP_LOAD_GLOBAL: begin
            if (entry_index < DESC_ENTRIES)
              gdt_copy[entry_index[DESC_AW-1:0]] = entry_data;
          end
          OP_LOAD_LOCAL: begin
            if (entry_index < DESC_ENTRIES)
              ldt_copy[entry_index[DESC_AW-1:0]] = entry_data;
          end
          OP_LOAD_DIR:    if (entry_index < PAGE_ENTRIES) dir_copy[entry_index] = entry_data;
          OP_LOAD_PAGE:   if (entry_index < PAGE_ENTRIES) pt_copy[entry_index]  = entry_data;
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_GLOBAL_COUNT:    global_count_q = pwdata[GCNT_W-1:0];
          REG_LOCAL_COUNT:     local_count_q  = pwdata[GCNT_W-1:0];
          REG_DIRECTORY_COUNT: dir_count_q    = pwdata[PCNT_W-1:0];
          REG_PAGETABLE_COUNT: page_count_q   = pwdata[PCNT_W-1:0];
          default: ;
        endcase
      end
      outstanding = awaited_xlates.size();
    end
  end

endmodule

### tb/sv/segment_and_page_translation_unit_test.sv
// Testbench top for the segment and page translation unit: clock, reset,
// stimulus and verdict. Depends on stpt_pkg, the unit and its checker.
module segment_and_page_translation_unit_test;
  import stpt_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_BEATS  = 70;
  localparam int PHASE_COUNT  = 8;
  localparam int SETTLE       = 16;
  localparam int MAX_DESC     = 32;
  localparam int MAX_DIR      = 32;
  localparam int MAX_PAGE     = 128;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  op;
  logic [9:0]  entry_index;
  logic [63:0] entry_data;
  logic [31:0] logical_address;
  logic [15:0] segment_selector;
  logic        empty;
  logic        pop = 1'b0;
  logic        invalid;
  logic [63:0] physical_address;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int outstanding;
  int results_checked;

  // Stimulus bookkeeping: programmed counts, and for each table the length of
  // the low prefix already loaded. A count is never raised past that prefix,
  // so no translation can read an entry that was never written.
  int  cur_global;
  int  cur_local;
  int  loaded_prefix [5];
  int  beats_sent;
  int  settings_applied;
  int  cycle_count;
  bit  calm = 1'b0;

  segment_and_page_translation_unit i_dut (.*);

  segment_and_page_translation_unit_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 13);
  endfunction

  // Result side: stall at random unless in the calm stretch.
  always @(negedge clk) pop <= !rst && !take_break();

  function automatic logic [63:0] pack_descriptor(logic [31:0] base, logic [19:0] limit,
                                                  logic gran, logic present);
    logic [63:0] d;
    d        = {$urandom, $urandom};
    d[15:0]  = limit[15:0];
    d[39:16] = base[23:0];
    d[47]    = present;
    d[51:48] = limit[19:16];
    d[55]    = gran;
    d[63:56] = base[31:24];
    return d;
  endfunction

  // Mostly present descriptors with large limits and bases in the low few
  // directory slots and low page slots, so most translations walk all the way
  // to the page table.
  function automatic logic [63:0] shaped_entry(logic [2:0] which);
    logic [31:0] base;
    logic [19:0] limit;
    logic [63:0] d;
    if (which == OP_LOAD_GLOBAL || which == OP_LOAD_LOCAL) begin
      limit = $urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom);
      if ($urandom_range(0, 4) != 0)
        base = ($urandom & 32'h0003FFFF) | ($urandom_range(0, 15) << 22);
      else
        base = $urandom;
      return pack_descriptor(base, limit, $urandom_range(0, 9) < 7,
                             $urandom_range(0, 9) != 0);
    end
    d    = {$urandom, $urandom};
    d[0] = $urandom_range(0, 9) != 0;
    return d;
  endfunction

  // Present one beat at a falling edge and hold it until the unit takes it.
  task automatic send_beat(input logic [2:0] o, input logic [9:0] ix, input logic [63:0] d,
                           input logic [31:0] la, input logic [15:0] s);
    while (take_break()) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push             <= 1'b1;
    op               <= o;
    entry_index      <= ix;
    entry_data       <= d;
    logical_address  <= la;
    segment_selector <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic fill_prefix(input logic [2:0] which, input int target);
    for (int i = loaded_prefix[which]; i < target; i++)
      send_beat(which, 10'(i), shaped_entry(which), $urandom, 16'($urandom));
    if (target > loaded_prefix[which]) loaded_prefix[which] = target;
  endtask

  // Setup cycle, then access cycle; returns at the falling edge after the
  // access so that the next write can start its setup right there.
  task automatic write_reg(input reg_idx_t r, input int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  // Load whatever the new counts need, drain, let trailing loads settle in
  // the engine, then program all four counts.
  task automatic set_counts(input int g, input int l, input int d, input int p);
    fill_prefix(OP_LOAD_GLOBAL, g);
    fill_prefix(OP_LOAD_LOCAL, l);
    fill_prefix(OP_LOAD_DIR, d);
    fill_prefix(OP_LOAD_PAGE, p);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    write_reg(REG_GLOBAL_COUNT, g);
    write_reg(REG_LOCAL_COUNT, l);
    write_reg(REG_DIRECTORY_COUNT, d);
    write_reg(REG_PAGETABLE_COUNT, p);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_global = g;
    cur_local  = l;
    settings_applied++;
  endtask

  // One random beat: mostly well-formed translations into loaded descriptors,
  // then shaped loads, then raw noise (any op, any field value).
  task automatic random_beat(output bit counted);
    int          pick;
    int          cnt;
    bit          use_local;
    logic [2:0]  o;
    logic [9:0]  ix;
    logic [12:0] idx;
    logic [15:0] s;
    logic [31:0] la;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      o  = 3'($urandom_range(0, 7));
      ix = 10'($urandom);
      counted = (o == OP_XLATE) || (o == OP_LOAD_DIR) || (o == OP_LOAD_PAGE) ||
                ((o == OP_LOAD_GLOBAL || o == OP_LOAD_LOCAL) && ix < DESC_ENTRIES);
      send_beat(o, ix, {$urandom, $urandom}, $urandom, 16'($urandom));
    end else if (pick < 45) begin
      o  = 3'($urandom_range(1, 4));
      ix = 10'((o == OP_LOAD_GLOBAL || o == OP_LOAD_LOCAL)
               ? $urandom_range(0, DESC_ENTRIES - 1)
               : $urandom_range(0, PAGE_ENTRIES - 1));
      counted = 1'b1;
      send_beat(o, ix, shaped_entry(o), $urandom, 16'($urandom));
    end else begin
      if (cur_global == 0 && cur_local == 0) begin
        s = 16'($urandom);
      end else begin
        if (cur_local == 0)       use_local = 1'b0;
        else if (cur_global == 0) use_local = 1'b1;
        else                      use_local = $urandom_range(0, 1);
        cnt = use_local ? cur_local : cur_global;
        idx = 13'($urandom_range(0, cnt - 1));
        s   = {idx, use_local, 2'($urandom)};
      end
      pick = $urandom_range(0, 9);
      if (pick < 6)      la = $urandom_range(0, 32'h0003FFFF);
      else if (pick < 8) la = $urandom_range(0, 32'h00000FFF);
      else               la = $urandom;
      counted = 1'b1;
      send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, la, s);
    end
  endtask

  // Watchdog: a stuck handshake or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int  done;
    bit  counted;
    int  g, l, d, p;
    rst              = 1'b1;
    push             = 1'b0;
    op               = '0;
    entry_index      = '0;
    entry_data       = '0;
    logical_address  = '0;
    segment_selector = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    beats_sent       = 0;
    settings_applied = 0;
    cur_global       = 0;
    cur_local        = 0;
    loaded_prefix    = '{default: 0};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: all counts still zero, so any index is out of range.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h0, 16'h0008);

    set_counts(4, 4, 8, 16);
    // Hand-built entries: a missing descriptor, byte and page granular limits,
    // a base that carries past 32 bits, a missing directory entry and a
    // present and a missing page.
    send_beat(OP_LOAD_GLOBAL, 10'd1, pack_descriptor(32'h0, 20'hFFFFF, 1'b1, 1'b0),
              $urandom, 16'($urandom));
    send_beat(OP_LOAD_GLOBAL, 10'd2, pack_descriptor(32'h0, 20'h0FFFF, 1'b0, 1'b1),
              $urandom, 16'($urandom));
    send_beat(OP_LOAD_GLOBAL, 10'd3, pack_descriptor(32'hFFFFF000, 20'hFFFFF, 1'b1, 1'b1),
              $urandom, 16'($urandom));
    send_beat(OP_LOAD_LOCAL, 10'd1, pack_descriptor(32'h00400000, 20'h00010, 1'b1, 1'b1),
              $urandom, 16'($urandom));
    send_beat(OP_LOAD_LOCAL, 10'd2, pack_descriptor(32'h0, 20'hFFFFF, 1'b1, 1'b1),
              $urandom, 16'($urandom));
    send_beat(OP_LOAD_DIR, 10'd0, {$urandom, $urandom} | 64'd1, $urandom, 16'($urandom));
    send_beat(OP_LOAD_DIR, 10'd1, {$urandom, $urandom} & ~64'd1, $urandom, 16'($urandom));
    send_beat(OP_LOAD_PAGE, 10'd5, {$urandom, $urandom} | 64'd1, $urandom, 16'($urandom));
    send_beat(OP_LOAD_PAGE, 10'd6, {$urandom, $urandom} & ~64'd1, $urandom, 16'($urandom));
    // Load past the descriptor table depth, and an unknown op: both dropped.
    send_beat(OP_LOAD_GLOBAL, 10'd300, {$urandom, $urandom}, $urandom, 16'($urandom));
    send_beat(3'd5, 10'h3FF, '1, '1, '1);

    // Null selectors, with and without the low privilege bits.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'hFFFFFFFF, 16'h0000);
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h0, 16'h0003);
    // Index equal to the global count.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h0, 16'h0020);
    // Descriptor without the present bit.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h0, 16'h0008);
    // Byte granular limit: offset at the limit passes, one past fails.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h0000FFFF, 16'h0013);
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h00010000, 16'h0010);
    // Full walk to a present page, then to a missing one.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h00005ABC, 16'h0010);
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h00006ABC, 16'h0010);
    // Linear address carry out of 32 bits.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h00001000, 16'h0018);
    // Page granular limit: at the scaled limit reaches a missing directory
    // entry; one past is rejected.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h00010000, 16'h000C);
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h00010001, 16'h000C);
    // Table index equal to the page-table count, directory index equal to
    // the directory count.
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h00010000, 16'h0014);
    send_beat(OP_XLATE, 10'($urandom), {$urandom, $urandom}, 32'h02000000, 16'h0014);

    // Random phases: the largest counts with no idling, all zero, all one,
    // then random counts biased toward a directory that covers the bases.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin g = MAX_DESC; l = MAX_DESC; d = MAX_DIR; p = MAX_PAGE; end
        1: begin g = 0; l = 0; d = 0; p = 0; end
        2: begin g = 1; l = 1; d = 1; p = 1; end
        default: begin
          g = $urandom_range(0, MAX_DESC);
          l = $urandom_range(0, MAX_DESC);
          d = ($urandom_range(0, 4) != 0) ? $urandom_range(16, MAX_DIR)
                                          : $urandom_range(0, 15);
          p = $urandom_range(1, MAX_PAGE);
        end
      endcase
      set_counts(g, l, d, p);
      calm <= (ph == 0);
      done = 0;
      while (done < PHASE_BEATS) begin
        random_beat(counted);
        done += counted;
      end
    end

    // Drain: wait out every translation, then the engine's tail.
    push <= 1'b0;
    calm <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d input beats, %0d translation results checked, %0d count settings.",
             beats_sent, results_checked, settings_applied);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
